// ===== hw/rtl/ssws_pkg.sv =====
`default_nettype none

package ssws_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SCORE_W     = 7;
    localparam int RANK_W      = 6;
    localparam int SUM_W       = 13;
    localparam int CMP_W       = CNT_W + RANK_W;

    localparam logic [SCORE_W-1:0] SCORE_MAX   = 7'd100;
    localparam logic [SCORE_W-1:0] GRADE_A_MIN = 7'd90;
    localparam logic [SCORE_W-1:0] GRADE_B_MIN = 7'd80;
    localparam logic [SCORE_W-1:0] GRADE_C_MIN = 7'd70;
    localparam logic [SCORE_W-1:0] GRADE_D_MIN = 7'd60;
    localparam logic [SUM_W-1:0]   SUM_LIMIT   = 13'd8191;
    localparam int                 NUM_CLASSES = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SCORE = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_RANK  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        LT_A = 3'd0,
        LT_B = 3'd1,
        LT_C = 3'd2,
        LT_D = 3'd3,
        LT_F = 3'd4
    } t_letter;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd_rank;
        logic rd_prev;
        logic wr_new;
        logic wr_shift;
        logic clear;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op     op;
        t_status code;
        logic    k_zero;
        logic    rd_ge;
    } t_stat;

    function automatic t_letter letter_of(input logic [SCORE_W-1:0] s);
        t_letter l;
        if (s >= GRADE_A_MIN) begin
            l = LT_A;
        end else if (s >= GRADE_B_MIN) begin
            l = LT_B;
        end else if (s >= GRADE_C_MIN) begin
            l = LT_C;
        end else if (s >= GRADE_D_MIN) begin
            l = LT_D;
        end else begin
            l = LT_F;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/score_sorter_with_statistics.sv =====
`default_nettype none

// Keeps up to 64 scores (0..100) sorted highest first, with entry count, highest, lowest,
// running total and A/B/C/D/F class counts. One transaction in gives one result out.
// Insert walks the store from the tail, moving each lower entry down one place with a
// read-compare-write pair through the store's read and write ports, and writes the new
// score once a stored score at or above it is met or the head is reached. Read rank,
// clear and rejected inserts go straight from decode to finish. The result register
// lets a new transaction in while a result is held.

module score_sorter_with_statistics (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [6:0]  i_score,
    input  wire logic [5:0]  i_rank,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [6:0]       o_rank_score,
    output logic [2:0]       o_letter,
    output logic [6:0]       o_entry_count,
    output logic [6:0]       o_highest,
    output logic [6:0]       o_lowest,
    output logic [12:0]      o_total,
    output logic [6:0]       o_count_a,
    output logic [6:0]       o_count_b,
    output logic [6:0]       o_count_c,
    output logic [6:0]       o_count_d,
    output logic [6:0]       o_count_f
);

    ssws_pkg::t_cmd  cmd;
    ssws_pkg::t_stat stat;

    ssws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ssws_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_score       (i_score),
        .i_rank        (i_rank),
        .o_status      (o_status),
        .o_rank_score  (o_rank_score),
        .o_letter      (o_letter),
        .o_entry_count (o_entry_count),
        .o_highest     (o_highest),
        .o_lowest      (o_lowest),
        .o_total       (o_total),
        .o_count_a     (o_count_a),
        .o_count_b     (o_count_b),
        .o_count_c     (o_count_c),
        .o_count_d     (o_count_d),
        .o_count_f     (o_count_f)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ssws_ctrl.sv =====
`default_nettype none

module ssws_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire ssws_pkg::t_stat i_stat,
    output ssws_pkg::t_cmd      o_cmd
);

    ssws_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssws_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ssws_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ssws_pkg::S_DECODE;
                end
            end
            ssws_pkg::S_DECODE: begin
                n_state = ssws_pkg::S_FINISH;
                if (i_stat.code == ssws_pkg::ST_OK) begin
                    if (i_stat.op == ssws_pkg::OP_INSERT) begin
                        n_state = ssws_pkg::S_INS_RD;
                    end else if (i_stat.op == ssws_pkg::OP_READ) begin
                        o_cmd.rd_rank = 1'b1;
                    end else if (i_stat.op == ssws_pkg::OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end
                end
            end
            ssws_pkg::S_INS_RD: begin
                if (i_stat.k_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = ssws_pkg::S_FINISH;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = ssws_pkg::S_INS_CMP;
                end
            end
            ssws_pkg::S_INS_CMP: begin
                if (i_stat.rd_ge) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = ssws_pkg::S_FINISH;
                end else begin
                    o_cmd.wr_shift = 1'b1;
                    n_state = ssws_pkg::S_INS_RD;
                end
            end
            ssws_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ssws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssws_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ssws_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/ssws_datapath.sv =====
`default_nettype none

module ssws_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ssws_pkg::t_cmd              i_cmd,
    output ssws_pkg::t_stat                  o_stat,
    input  wire logic [1:0]                  i_operation,
    input  wire logic [ssws_pkg::SCORE_W-1:0] i_score,
    input  wire logic [ssws_pkg::RANK_W-1:0]  i_rank,
    output logic [1:0]                       o_status,
    output logic [6:0]                       o_rank_score,
    output logic [2:0]                       o_letter,
    output logic [6:0]                       o_entry_count,
    output logic [6:0]                       o_highest,
    output logic [6:0]                       o_lowest,
    output logic [12:0]                      o_total,
    output logic [6:0]                       o_count_a,
    output logic [6:0]                       o_count_b,
    output logic [6:0]                       o_count_c,
    output logic [6:0]                       o_count_d,
    output logic [6:0]                       o_count_f
);

    localparam int AW = ssws_pkg::ADDR_W;
    localparam int CW = ssws_pkg::CNT_W;
    localparam int SW = ssws_pkg::SCORE_W;

    logic [SW-1:0] mem [ssws_pkg::MAX_ENTRIES];

    ssws_pkg::t_op     r_op;
    ssws_pkg::t_status r_code, n_code;
    logic [SW-1:0]     r_score;
    logic [AW-1:0]     r_rank;
    logic [AW-1:0]     r_k;
    logic [SW-1:0]     r_rdata;

    logic [CW-1:0]              r_count;
    logic [SW-1:0]              r_high;
    logic [SW-1:0]              r_low;
    logic [ssws_pkg::SUM_W-1:0] r_sum;
    logic [CW-1:0]              r_cls [ssws_pkg::NUM_CLASSES];

    logic [ssws_pkg::SUM_W:0] n_sum;
    ssws_pkg::t_letter        new_letter;
    ssws_pkg::t_letter        rd_letter;
    logic                     rank_ok;
    logic                     full;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [SW-1:0]            wr_data;
    logic                     rank_hit;

    assign full    = r_count >= CW'(ssws_pkg::MAX_ENTRIES);
    assign rank_ok = ssws_pkg::CMP_W'(i_rank) < ssws_pkg::CMP_W'(r_count);

    always_comb begin
        n_code = ssws_pkg::ST_OK;
        case (ssws_pkg::t_op'(i_operation))
            ssws_pkg::OP_INSERT: begin
                if (i_score > ssws_pkg::SCORE_MAX) begin
                    n_code = ssws_pkg::ST_BAD_SCORE;
                end else if (full) begin
                    n_code = ssws_pkg::ST_FULL;
                end
            end
            ssws_pkg::OP_READ: begin
                if (!rank_ok) begin
                    n_code = ssws_pkg::ST_BAD_RANK;
                end
            end
            default: begin
                n_code = ssws_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= ssws_pkg::t_op'(i_operation);
            r_code  <= n_code;
            r_score <= i_score;
            r_rank  <= AW'(i_rank);
            r_k     <= AW'(r_count);
        end else if (i_cmd.wr_shift) begin
            r_k <= r_k - 1'b1;
        end
    end

    // simple dual-port store: one read and one write per cycle, registered read
    assign rd_en   = i_cmd.rd_rank || i_cmd.rd_prev;
    assign rd_addr = i_cmd.rd_rank ? r_rank : r_k - 1'b1;
    assign wr_en   = i_cmd.wr_new || i_cmd.wr_shift;
    assign wr_data = i_cmd.wr_new ? r_score : r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_k] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign new_letter = ssws_pkg::letter_of(r_score);
    assign n_sum      = {1'b0, r_sum} + (ssws_pkg::SUM_W + 1)'(r_score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_high  <= '0;
            r_low   <= '0;
            r_sum   <= '0;
            for (int i = 0; i < ssws_pkg::NUM_CLASSES; i++) begin
                r_cls[i] <= '0;
            end
        end else if (i_cmd.wr_new) begin
            r_count <= r_count + 1'b1;
            if (r_count == '0 || r_score > r_high) begin
                r_high <= r_score;
            end
            if (r_count == '0 || r_score < r_low) begin
                r_low <= r_score;
            end
            if (n_sum > (ssws_pkg::SUM_W + 1)'(ssws_pkg::SUM_LIMIT)) begin
                r_sum <= ssws_pkg::SUM_LIMIT;
            end else begin
                r_sum <= n_sum[ssws_pkg::SUM_W-1:0];
            end
            for (int i = 0; i < ssws_pkg::NUM_CLASSES; i++) begin
                if (new_letter == ssws_pkg::t_letter'(3'(i))) begin
                    r_cls[i] <= r_cls[i] + 1'b1;
                end
            end
        end
    end

    assign rank_hit  = (r_op == ssws_pkg::OP_READ) && (r_code == ssws_pkg::ST_OK);
    assign rd_letter = ssws_pkg::letter_of(r_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status      <= r_code;
            o_rank_score  <= rank_hit ? r_rdata : '0;
            o_letter      <= rank_hit ? rd_letter : ssws_pkg::LT_A;
            o_entry_count <= 7'(r_count);
            o_highest     <= r_high;
            o_lowest      <= r_low;
            o_total       <= r_sum;
            o_count_a     <= 7'(r_cls[0]);
            o_count_b     <= 7'(r_cls[1]);
            o_count_c     <= 7'(r_cls[2]);
            o_count_d     <= 7'(r_cls[3]);
            o_count_f     <= 7'(r_cls[4]);
        end
    end

    assign o_stat.op     = r_op;
    assign o_stat.code   = r_code;
    assign o_stat.k_zero = (r_k == '0);
    assign o_stat.rd_ge  = (r_rdata >= r_score);

endmodule

`default_nettype wire
